// ===== sv/cfot_pkg.sv =====
// cfot_pkg: widths, constants and shared types of the capsule/face overlap test
// depends on nothing; imported by capsule_face_overlap_test and cfot_checker

package cfot_pkg;

  // field widths
  localparam int POS_W  = 24;  // signed Q15.8 position
  localparam int NRM_W  = 16;  // signed Q1.14 normal component
  localparam int CFG_W  = 23;  // unsigned Q15.8 register
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // internal widths
  localparam int DIF_W  = POS_W + 1;        // centre minus face, Q.8
  localparam int PX_W   = DIF_W + 1;        // doubled difference, Q.9
  localparam int PY_W   = PX_W + 1;         // test point y, Q.9
  localparam int CHH_W  = CFG_W + 2;        // half cylinder length, Q.9
  localparam int P1_W   = DIF_W + NRM_W;    // one centre product, Q.22
  localparam int D0_W   = P1_W + 2;         // centre plane distance, Q.22
  localparam int LIM0_W = CFG_W + 14;       // reject threshold, Q.22
  localparam int Q_W    = PY_W + NRM_W;     // one test point product, Q.23
  localparam int DST_W  = Q_W + 2;          // test point plane distance, Q.23
  localparam int M_W    = DST_W + NRM_W;    // normal times distance, Q.37
  localparam int L_W    = M_W + 1;          // in-plane offset, Q.37
  localparam int CMP_W  = L_W + 1;          // offset compare width

  // constants
  localparam int TENTH_Q22 = 419430;        // 0.1 in Q.22
  localparam int HALF_Q14  = 8192;          // 0.5 in Q.14
  localparam int LIM_FRAC_SH = 36;          // 0.5 in Q.37 is 2^36
  localparam int RAD_D_SH  = 15;            // Q.8 radius into Q.23
  localparam int RAD_L_SH  = 29;            // Q.8 radius into Q.37
  localparam int H_HALF_SH = 13;            // Q.8 height into Q.22, halved
  localparam int PT_SH     = 28;            // Q.9 point into Q.37

  // register reset values
  localparam logic [CFG_W-1:0] RADIUS_RST = CFG_W'(77);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(461);

  // register index, taken from paddr bit 2
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // fields that ride along the pipe to the result
  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    last;
  } side_t;

endpackage

// ===== sv/capsule_face_overlap_test.sv =====
// capsule_face_overlap_test: six-stage pipelined capsule vs unit square face test
// depends on cfot_pkg
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+------------------------------
//  input    | in_center_*, in_face_*, in_norm_*, .. | in_valid / in_ready
//  result   | out_hit, out_hit_norm_*, out_query_end| out_valid / out_ready
//  config   | psel penable pwrite paddr pwdata ..   | apb write, pready tied high
//
// one word per cycle sustained while the result side is not stalled; each word passes
// through the stage 1 to stage 5 registers into the result register.
// reset (rst_n low, synchronous) clears the stage valids and restores the
// radius and height registers; data registers are not reset.
// a stall at the output holds the result; earlier stages keep moving into
// empty stages, so bubbles collapse and nothing is dropped or repeated.

module capsule_face_overlap_test (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [cfot_pkg::POS_W-1:0] in_center_x,
  input  logic signed [cfot_pkg::POS_W-1:0] in_center_y,
  input  logic signed [cfot_pkg::POS_W-1:0] in_center_z,
  input  logic signed [cfot_pkg::POS_W-1:0] in_face_x,
  input  logic signed [cfot_pkg::POS_W-1:0] in_face_y,
  input  logic signed [cfot_pkg::POS_W-1:0] in_face_z,
  input  logic signed [cfot_pkg::NRM_W-1:0] in_norm_x,
  input  logic signed [cfot_pkg::NRM_W-1:0] in_norm_y,
  input  logic signed [cfot_pkg::NRM_W-1:0] in_norm_z,
  input  logic                             in_last_face,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic signed [cfot_pkg::NRM_W-1:0] out_hit_norm_x,
  output logic signed [cfot_pkg::NRM_W-1:0] out_hit_norm_y,
  output logic signed [cfot_pkg::NRM_W-1:0] out_hit_norm_z,
  output logic                             out_query_end,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cfot_pkg::ADDR_W-1:0]      paddr,
  input  logic [cfot_pkg::DATA_W-1:0]      pwdata,
  output logic [cfot_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import cfot_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] radius_r, height_r;
  logic             cfg_wr;

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, ov_r;
  logic en1, en2, en3, en4, en5, en6;

  // side fields per stage
  side_t s_in, s1_r, s2_r, s3_r, s4_r, s5_r, so_r;

  // stage 1: differences
  logic signed [DIF_W-1:0] dx_nxt, dy_nxt, dz_nxt, dx1_r, dy1_r, dz1_r;

  // stage 2: centre products, test point
  logic signed [P1_W-1:0]  pdx_nxt, pdy_nxt, pdz_nxt, pdx2_r, pdy2_r, pdz2_r;
  logic signed [CHH_W-1:0] chh;
  logic signed [PY_W-1:0]  dy2, yoff, chh_e, py_nxt, py2_r;
  logic signed [PX_W-1:0]  px_nxt, pz_nxt, px2_r, pz2_r;

  // stage 3: reject test, point products
  logic signed [D0_W-1:0]   d0;
  logic signed [D0_W:0]     d0_e, lim0_e;
  logic [LIM0_W-1:0]        lim0;
  logic                     ok0_nxt, ok0_3_r;
  logic signed [Q_W-1:0]    qx_nxt, qy_nxt, qz_nxt, qx3_r, qy3_r, qz3_r;
  logic signed [PX_W-1:0]   px3_r, pz3_r;
  logic signed [PY_W-1:0]   py3_r;

  // stage 4: point plane distance
  logic signed [DST_W-1:0]  dist_nxt, dist4_r;
  logic signed [DST_W:0]    dist_e, lim1_e;
  logic                     ok_nxt, ok4_r;
  logic signed [PX_W-1:0]   px4_r, pz4_r;
  logic signed [PY_W-1:0]   py4_r;

  // stage 5: normal times distance
  logic signed [M_W-1:0]    mx_nxt, my_nxt, mz_nxt, mx5_r, my5_r, mz5_r;
  logic                     ok5_r;
  logic signed [PX_W-1:0]   px5_r, pz5_r;
  logic signed [PY_W-1:0]   py5_r;

  // stage 6: in-plane offsets and final flag
  logic signed [L_W-1:0]    lx, ly, lz;
  logic signed [CMP_W-1:0]  lx_e, ly_e, lz_e, lim_e;
  logic                     in_x, in_y, in_z, big_nx, big_nz, hit_nxt, hit_r;

  // apb write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RADIUS: radius_r <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = DATA_W'(radius_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // stage enables: a stage moves when it is empty or the next one moves
  assign en6 = !ov_r || out_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) ov_r <= v5_r;
    end
  end

  // stage 1 logic: centre minus face
  assign dx_nxt = DIF_W'(in_center_x) - DIF_W'(in_face_x);
  assign dy_nxt = DIF_W'(in_center_y) - DIF_W'(in_face_y);
  assign dz_nxt = DIF_W'(in_center_z) - DIF_W'(in_face_z);
  assign s_in   = '{nx: in_norm_x, ny: in_norm_y, nz: in_norm_z, last: in_last_face};

  // stage 2 logic: centre products and choice of axis point
  assign pdx_nxt = P1_W'(dx1_r) * P1_W'(s1_r.nx);
  assign pdy_nxt = P1_W'(dy1_r) * P1_W'(s1_r.ny);
  assign pdz_nxt = P1_W'(dz1_r) * P1_W'(s1_r.nz);
  assign chh     = $signed({2'b00, height_r}) - $signed({1'b0, radius_r, 1'b0});
  assign chh_e   = PY_W'(chh);
  assign dy2     = $signed({dy1_r[DIF_W-1], dy1_r, 1'b0});
  assign yoff    = -dy2;
  assign px_nxt  = $signed({dx1_r, 1'b0});
  assign pz_nxt  = $signed({dz1_r, 1'b0});

  // top sphere first, then bottom sphere, else the point at face height
  always_comb begin
    if (yoff > chh_e) begin
      py_nxt = dy2 + chh_e;
    end else if (yoff < -chh_e) begin
      py_nxt = dy2 - chh_e;
    end else begin
      py_nxt = '0;
    end
  end

  // stage 3 logic: quick reject and point products
  assign d0      = D0_W'(pdx2_r) + D0_W'(pdy2_r) + D0_W'(pdz2_r);
  assign lim0    = LIM0_W'({height_r, {H_HALF_SH{1'b0}}}) + LIM0_W'(TENTH_Q22);
  assign d0_e    = (D0_W+1)'(d0);
  assign lim0_e  = $signed((D0_W+1)'(lim0));
  assign ok0_nxt = (d0_e <= lim0_e) && (d0_e >= -lim0_e);
  assign qx_nxt  = Q_W'(px2_r) * Q_W'(s2_r.nx);
  assign qy_nxt  = Q_W'(py2_r) * Q_W'(s2_r.ny);
  assign qz_nxt  = Q_W'(pz2_r) * Q_W'(s2_r.nz);

  // stage 4 logic: point plane distance against radius
  assign dist_nxt = DST_W'(qx3_r) + DST_W'(qy3_r) + DST_W'(qz3_r);
  assign dist_e   = (DST_W+1)'(dist_nxt);
  assign lim1_e   = $signed((DST_W+1)'({radius_r, {RAD_D_SH{1'b0}}}));
  assign ok_nxt   = ok0_3_r && (dist_e <= lim1_e) && (dist_e >= -lim1_e);

  // stage 5 logic: normal scaled by distance
  assign mx_nxt = M_W'(s4_r.nx) * M_W'(dist4_r);
  assign my_nxt = M_W'(s4_r.ny) * M_W'(dist4_r);
  assign mz_nxt = M_W'(s4_r.nz) * M_W'(dist4_r);

  // stage 6 logic: offsets inside half plus radius on the two face axes
  assign lx     = L_W'($signed({px5_r, {PT_SH{1'b0}}})) - L_W'(mx5_r);
  assign ly     = L_W'($signed({py5_r, {PT_SH{1'b0}}})) - L_W'(my5_r);
  assign lz     = L_W'($signed({pz5_r, {PT_SH{1'b0}}})) - L_W'(mz5_r);
  assign lx_e   = CMP_W'(lx);
  assign ly_e   = CMP_W'(ly);
  assign lz_e   = CMP_W'(lz);
  assign lim_e  = $signed(CMP_W'({radius_r, {RAD_L_SH{1'b0}}}) + (CMP_W'(1) << LIM_FRAC_SH));
  assign in_x   = (lx_e <= lim_e) && (lx_e >= -lim_e);
  assign in_y   = (ly_e <= lim_e) && (ly_e >= -lim_e);
  assign in_z   = (lz_e <= lim_e) && (lz_e >= -lim_e);
  assign big_nx = (s5_r.nx > NRM_W'(HALF_Q14)) || (s5_r.nx < -NRM_W'(HALF_Q14));
  assign big_nz = (s5_r.nz > NRM_W'(HALF_Q14)) || (s5_r.nz < -NRM_W'(HALF_Q14));

  always_comb begin
    if (big_nx) begin
      hit_nxt = ok5_r && in_y && in_z;
    end else if (big_nz) begin
      hit_nxt = ok5_r && in_x && in_y;
    end else begin
      hit_nxt = ok5_r && in_x && in_z;
    end
  end

  // data registers, loaded with their stage enable
  always_ff @(posedge clk) begin
    if (en1) begin
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
      dz1_r <= dz_nxt;
      s1_r  <= s_in;
    end
    if (en2) begin
      pdx2_r <= pdx_nxt;
      pdy2_r <= pdy_nxt;
      pdz2_r <= pdz_nxt;
      px2_r  <= px_nxt;
      py2_r  <= py_nxt;
      pz2_r  <= pz_nxt;
      s2_r   <= s1_r;
    end
    if (en3) begin
      ok0_3_r <= ok0_nxt;
      qx3_r   <= qx_nxt;
      qy3_r   <= qy_nxt;
      qz3_r   <= qz_nxt;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      pz3_r   <= pz2_r;
      s3_r    <= s2_r;
    end
    if (en4) begin
      ok4_r   <= ok_nxt;
      dist4_r <= dist_nxt;
      px4_r   <= px3_r;
      py4_r   <= py3_r;
      pz4_r   <= pz3_r;
      s4_r    <= s3_r;
    end
    if (en5) begin
      ok5_r <= ok4_r;
      mx5_r <= mx_nxt;
      my5_r <= my_nxt;
      mz5_r <= mz_nxt;
      px5_r <= px4_r;
      py5_r <= py4_r;
      pz5_r <= pz4_r;
      s5_r  <= s4_r;
    end
    if (en6) begin
      hit_r <= hit_nxt;
      so_r  <= s5_r;
    end
  end

  // result word
  assign out_valid      = ov_r;
  assign out_hit        = hit_r;
  assign out_hit_norm_x = so_r.nx;
  assign out_hit_norm_y = so_r.ny;
  assign out_hit_norm_z = so_r.nz;
  assign out_query_end  = so_r.last;

endmodule

// ===== sv/cfot_checker.sv =====
// cfot_checker: port-level assertions for capsule_face_overlap_test, bound to the top
// depends on cfot_pkg and on capsule_face_overlap_test

module cfot_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hit,
  input logic signed [cfot_pkg::NRM_W-1:0] out_hit_norm_x,
  input logic                              out_query_end
);
  import cfot_pkg::*;

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // when the result side moves or is empty, the whole pipe can take a word
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side is free");

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // and keeps its hit flag, x normal component and query end flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_hit) && $stable(out_hit_norm_x) && $stable(out_query_end))
    else $error("stalled result word changed");

endmodule

bind capsule_face_overlap_test cfot_checker u_cfot_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_hit_norm_x (out_hit_norm_x),
  .out_query_end  (out_query_end)
);
